FILE: hw/rtl/pulse_peak_bpm_tracker_unit_defines.svh
// Assertion macros shared by the pulse peak tracker checker.
`ifndef PULSE_PEAK_BPM_TRACKER_UNIT_DEFINES_SVH
`define PULSE_PEAK_BPM_TRACKER_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PPBT_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ppbt: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define PPBT_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ppbt: next-cycle check failed");

`endif

FILE: hw/rtl/ppbt_pkg.sv
// Types, constants and codes of the pulse peak rate tracker.
package ppbt_pkg;

    localparam int IR_W       = 18;
    localparam int TIME_W     = 16;
    localparam int RATE_W     = 16;
    localparam int AVG_W      = 8;
    localparam int STATUS_W   = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 18;
    localparam int COUNT_W    = 2;

    localparam int SAMPLE_DEPTH_DEF = 8;
    localparam int RATE_DEPTH_DEF   = 4;

    // Shared divider: dividend covers the widest window sum, two bits per cycle.
    localparam int DIV_W     = 24;
    localparam int DIVISOR_W = 16;

    localparam logic [RATE_W-1:0]  BPM_NUMERATOR = 16'd60000;
    localparam logic [RATE_W-1:0]  CLAMP_VALUE   = 16'd83;
    localparam logic [COUNT_W-1:0] COUNT_MAX     = 2'd3;

    localparam logic [IR_W-1:0]   FINGER_THR_RST = 18'd3000;
    localparam logic [IR_W-1:0]   RISE_THR_RST   = 18'd100;
    localparam logic [IR_W-1:0]   FALL_THR_RST   = 18'd50;
    localparam logic [TIME_W-1:0] MIN_IVL_RST    = 16'd300;
    localparam logic [TIME_W-1:0] MAX_IVL_RST    = 16'd2000;
    localparam logic [AVG_W-1:0]  ACCEPT_LOW_RST = 8'd60;
    localparam logic [AVG_W-1:0]  ACCEPT_HI_RST  = 8'd95;
    localparam logic [AVG_W-1:0]  CLAMP_LIM_RST  = 8'd97;

    // Register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_FINGER_THR = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RISE_THR   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FALL_THR   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_IVL    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_IVL    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_ACCEPT_LOW = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_ACCEPT_HI  = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_CLAMP_LIM  = 3'd7;

    // Result status codes.
    localparam logic [STATUS_W-1:0] ST_NO_FINGER = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NOTHING   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_REJECTED  = 2'd2;
    localparam logic [STATUS_W-1:0] ST_ACCEPTED  = 2'd3;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CHECK,
        S_MEAN_GO,
        S_MEAN_WAIT,
        S_PEAK,
        S_RATE_WAIT,
        S_AVG_GO,
        S_AVG_WAIT,
        S_FINISH
    } t_state;

    typedef enum logic [1:0] {
        DIV_MEAN,
        DIV_RATE,
        DIV_AVG
    } t_div_sel;

    typedef struct packed {
        logic     load_in;
        logic     no_finger;
        logic     win_update;
        logic     div_start;
        t_div_sel div_sel;
        logic     peak_eval;
        logic     rate_update;
        logic     avg_eval;
        logic     load_out;
    } t_cmd;

    typedef struct packed {
        logic below_finger;
        logic div_done;
        logic beat_go;
        logic out_free;
    } t_stat;

endpackage

FILE: hw/rtl/ppbt_if.sv
// Handshake channel interfaces: sample input, result output, register writes.
interface ppbt_in_if;
    import ppbt_pkg::*;
    logic              valid;
    logic              ready;
    logic [IR_W-1:0]   ir_sample;
    logic [TIME_W-1:0] now_ms;
    modport source (output valid, output ir_sample, output now_ms, input ready);
    modport sink   (input valid, input ir_sample, input now_ms, output ready);
endinterface

interface ppbt_out_if;
    import ppbt_pkg::*;
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic                beat_seen;
    logic [RATE_W-1:0]   beat_rate;
    logic [AVG_W-1:0]    avg_rate;
    modport source (output valid, output status, output beat_seen, output beat_rate,
                    output avg_rate, input ready);
    modport sink   (input valid, input status, input beat_seen, input beat_rate,
                    input avg_rate, output ready);
endinterface

interface ppbt_cfg_if;
    import ppbt_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: hw/rtl/ppbt_ram.sv
// Generic single-write, single-read RAM with registered read data.
module ppbt_ram #(
    parameter int WIDTH = 18,
    parameter int DEPTH = 8
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

FILE: hw/rtl/ppbt_div.sv
// Iterative restoring divider, two quotient bits per cycle.
module ppbt_div (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic [ppbt_pkg::DIV_W-1:0]     i_dividend,
    input  logic [ppbt_pkg::DIVISOR_W-1:0] i_divisor,
    output logic                           o_done,
    output logic [ppbt_pkg::DIV_W-1:0]     o_quot
);
    import ppbt_pkg::*;

    localparam int STEPS = DIV_W / 2;
    localparam int CNT_W = $clog2(STEPS + 1);

    logic [DIVISOR_W-1:0] r_rem, n_rem;
    logic [DIV_W-1:0]     r_quot, n_quot;
    logic [DIVISOR_W-1:0] r_div;
    logic [CNT_W-1:0]     r_cnt;
    logic                 r_busy;
    logic                 r_done;
    logic [DIVISOR_W:0]   step_a, step_b;

    // Returns {quotient bit, new remainder}.
    function automatic logic [DIVISOR_W:0] div_step(input logic [DIVISOR_W-1:0] rem,
                                                     input logic                 b,
                                                     input logic [DIVISOR_W-1:0] d);
        logic [DIVISOR_W:0] trial;
        trial = {rem, b};
        if (trial >= {1'b0, d}) begin
            div_step = {1'b1, DIVISOR_W'(trial - {1'b0, d})};
        end else begin
            div_step = {1'b0, trial[DIVISOR_W-1:0]};
        end
    endfunction

    always_comb begin
        step_a = div_step(r_rem, r_quot[DIV_W-1], r_div);
        step_b = div_step(step_a[DIVISOR_W-1:0], r_quot[DIV_W-2], r_div);
        n_rem  = step_b[DIVISOR_W-1:0];
        n_quot = {r_quot[DIV_W-3:0], step_a[DIVISOR_W], step_b[DIVISOR_W]};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(STEPS);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= '0;
            r_quot <= i_dividend;
            r_div  <= i_divisor;
        end else if (r_busy) begin
            r_rem  <= n_rem;
            r_quot <= n_quot;
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;
endmodule

FILE: hw/rtl/ppbt_datapath.sv
// Datapath: registers, sample and rate windows, shared divider, result register.
module ppbt_datapath #(
    parameter int SAMPLE_DEPTH = ppbt_pkg::SAMPLE_DEPTH_DEF,
    parameter int RATE_DEPTH   = ppbt_pkg::RATE_DEPTH_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  ppbt_pkg::t_cmd                  i_cmd,
    output ppbt_pkg::t_stat                 o_stat,
    input  logic [ppbt_pkg::IR_W-1:0]       i_ir_sample,
    input  logic [ppbt_pkg::TIME_W-1:0]     i_now_ms,
    input  logic                            i_cfg_we,
    input  logic [ppbt_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [ppbt_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                            i_out_ready,
    output logic                            o_out_valid,
    output logic [ppbt_pkg::STATUS_W-1:0]   o_status,
    output logic                            o_beat_seen,
    output logic [ppbt_pkg::RATE_W-1:0]     o_beat_rate,
    output logic [ppbt_pkg::AVG_W-1:0]      o_avg_rate
);
    import ppbt_pkg::*;

    localparam int SLOT_W  = $clog2(SAMPLE_DEPTH);
    localparam int SUM_W   = IR_W + SLOT_W;
    localparam int RSLOT_W = $clog2(RATE_DEPTH);
    localparam int RSUM_W  = RATE_W + RSLOT_W;
    localparam logic [SLOT_W-1:0]  SLOT_LAST  = SLOT_W'(SAMPLE_DEPTH - 1);
    localparam logic [RSLOT_W-1:0] RSLOT_LAST = RSLOT_W'(RATE_DEPTH - 1);

    // Configuration registers.
    logic [IR_W-1:0]   r_finger_thr, r_rise_thr, r_fall_thr;
    logic [TIME_W-1:0] r_min_ivl, r_max_ivl;
    logic [AVG_W-1:0]  r_accept_low, r_accept_hi, r_clamp_lim;

    // Tracker state.
    logic [SLOT_W-1:0]  r_slot;
    logic               r_wrapped;
    logic [SUM_W-1:0]   r_sum;
    logic               r_peak;
    logic               r_await;
    logic [TIME_W-1:0]  r_last_peak;
    logic [RATE_W-1:0]  r_rwin [RATE_DEPTH];
    logic [RSLOT_W-1:0] r_rslot;
    logic [RSUM_W-1:0]  r_rsum;
    logic [COUNT_W-1:0] r_count;

    // Current item and its result.
    logic [IR_W-1:0]     r_ir;
    logic [TIME_W-1:0]   r_now;
    logic [STATUS_W-1:0] r_res_status;
    logic                r_res_beat;
    logic [RATE_W-1:0]   r_res_rate;
    logic [AVG_W-1:0]    r_res_avg;

    // Output register.
    logic                r_out_valid;
    logic [STATUS_W-1:0] r_out_status;
    logic                r_out_beat;
    logic [RATE_W-1:0]   r_out_rate;
    logic [AVG_W-1:0]    r_out_avg;

    logic [IR_W-1:0]      ram_rdata;
    logic [IR_W-1:0]      old_sample;
    logic [SUM_W-1:0]     sum_new;
    logic [IR_W-1:0]      mean;
    logic signed [IR_W:0] dev;
    logic                 rise_hit, fall_hit;
    logic [TIME_W-1:0]    dt;
    logic                 dt_ok;
    logic [RATE_W-1:0]    quot_rate;
    logic [RSUM_W-1:0]    rsum_new;
    logic [RATE_W-1:0]    avg_clamped;
    logic [DIV_W-1:0]     div_dividend;
    logic [DIVISOR_W-1:0] div_divisor;
    logic                 div_done;
    logic [DIV_W-1:0]     div_quot;

    ppbt_ram #(
        .WIDTH (IR_W),
        .DEPTH (SAMPLE_DEPTH)
    ) u_sample_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.win_update),
        .i_waddr (r_slot),
        .i_wdata (r_ir),
        .i_raddr (r_slot),
        .o_rdata (ram_rdata)
    );

    ppbt_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_done     (div_done),
        .o_quot     (div_quot)
    );

    always_comb begin
        // Entries not yet written since reset count as zero.
        old_sample  = r_wrapped ? ram_rdata : '0;
        sum_new     = (r_sum - SUM_W'(old_sample)) + SUM_W'(r_ir);
        mean        = div_quot[IR_W-1:0];
        dev         = $signed({1'b0, r_ir}) - $signed({1'b0, mean});
        rise_hit    = dev > $signed({1'b0, r_rise_thr});
        fall_hit    = dev < $signed({1'b0, r_fall_thr});
        dt          = r_now - r_last_peak;
        dt_ok       = (dt > r_min_ivl) && (dt < r_max_ivl) && (dt != '0);
        quot_rate   = div_quot[RATE_W-1:0];
        rsum_new    = (r_rsum - RSUM_W'(r_rwin[r_rslot])) + RSUM_W'(quot_rate);
        avg_clamped = (quot_rate > RATE_W'(r_clamp_lim)) ? CLAMP_VALUE : quot_rate;

        unique case (i_cmd.div_sel)
            DIV_MEAN: begin
                div_dividend = DIV_W'(r_sum);
                div_divisor  = DIVISOR_W'(SAMPLE_DEPTH);
            end
            DIV_RATE: begin
                div_dividend = DIV_W'(BPM_NUMERATOR);
                div_divisor  = dt;
            end
            DIV_AVG: begin
                div_dividend = DIV_W'(r_rsum);
                div_divisor  = DIVISOR_W'(RATE_DEPTH);
            end
            default: begin
                div_dividend = '0;
                div_divisor  = '0;
            end
        endcase

        o_stat.below_finger = r_ir < r_finger_thr;
        o_stat.div_done     = div_done;
        o_stat.beat_go      = rise_hit && !r_peak && !r_await && dt_ok;
        o_stat.out_free     = !r_out_valid || i_out_ready;
    end

    // Configuration registers and tracker state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_finger_thr <= FINGER_THR_RST;
            r_rise_thr   <= RISE_THR_RST;
            r_fall_thr   <= FALL_THR_RST;
            r_min_ivl    <= MIN_IVL_RST;
            r_max_ivl    <= MAX_IVL_RST;
            r_accept_low <= ACCEPT_LOW_RST;
            r_accept_hi  <= ACCEPT_HI_RST;
            r_clamp_lim  <= CLAMP_LIM_RST;
            r_slot       <= '0;
            r_wrapped    <= 1'b0;
            r_sum        <= '0;
            r_peak       <= 1'b0;
            r_await      <= 1'b1;
            r_last_peak  <= '0;
            for (int i = 0; i < RATE_DEPTH; i++) begin
                r_rwin[i] <= '0;
            end
            r_rslot      <= '0;
            r_rsum       <= '0;
            r_count      <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_FINGER_THR: r_finger_thr <= i_cfg_data;
                    CFG_RISE_THR:   r_rise_thr   <= i_cfg_data;
                    CFG_FALL_THR:   r_fall_thr   <= i_cfg_data;
                    CFG_MIN_IVL:    r_min_ivl    <= i_cfg_data[TIME_W-1:0];
                    CFG_MAX_IVL:    r_max_ivl    <= i_cfg_data[TIME_W-1:0];
                    CFG_ACCEPT_LOW: r_accept_low <= i_cfg_data[AVG_W-1:0];
                    CFG_ACCEPT_HI:  r_accept_hi  <= i_cfg_data[AVG_W-1:0];
                    CFG_CLAMP_LIM:  r_clamp_lim  <= i_cfg_data[AVG_W-1:0];
                    default: ;
                endcase
            end

            if (i_cmd.no_finger) begin
                r_await <= 1'b1;
                r_count <= '0;
            end

            if (i_cmd.win_update) begin
                r_sum  <= sum_new;
                if (r_slot == SLOT_LAST) begin
                    r_slot    <= '0;
                    r_wrapped <= 1'b1;
                end else begin
                    r_slot <= r_slot + 1'b1;
                end
            end

            if (i_cmd.peak_eval) begin
                if (rise_hit && !r_peak) begin
                    r_peak      <= 1'b1;
                    r_last_peak <= r_now;
                    r_await     <= 1'b0;
                end
                // The fall test comes after the rise test and wins.
                if (fall_hit) begin
                    r_peak <= 1'b0;
                end
            end

            if (i_cmd.rate_update) begin
                r_rwin[r_rslot] <= quot_rate;
                r_rsum          <= rsum_new;
                r_rslot         <= (r_rslot == RSLOT_LAST) ? '0 : r_rslot + 1'b1;
                if (r_count != COUNT_MAX) begin
                    r_count <= r_count + 1'b1;
                end
            end

            if (i_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Item payload and result fields.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_ir         <= i_ir_sample;
            r_now        <= i_now_ms;
            r_res_status <= ST_NOTHING;
            r_res_beat   <= 1'b0;
            r_res_rate   <= '0;
            r_res_avg    <= '0;
        end
        if (i_cmd.no_finger) begin
            r_res_status <= ST_NO_FINGER;
        end
        if (i_cmd.rate_update) begin
            r_res_beat <= 1'b1;
            r_res_rate <= quot_rate;
        end
        if (i_cmd.avg_eval && (r_count == COUNT_MAX)) begin
            r_res_avg    <= avg_clamped[AVG_W-1:0];
            r_res_status <= ((avg_clamped > RATE_W'(r_accept_low)) &&
                             (avg_clamped < RATE_W'(r_accept_hi))) ? ST_ACCEPTED : ST_REJECTED;
        end
        if (i_cmd.load_out) begin
            r_out_status <= r_res_status;
            r_out_beat   <= r_res_beat;
            r_out_rate   <= r_res_rate;
            r_out_avg    <= r_res_avg;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_status    = r_out_status;
    assign o_beat_seen = r_out_beat;
    assign o_beat_rate = r_out_rate;
    assign o_avg_rate  = r_out_avg;
endmodule

FILE: hw/rtl/ppbt_ctrl.sv
// Controller state machine that sequences one sample through the datapath.
module ppbt_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  ppbt_pkg::t_stat i_stat,
    output ppbt_pkg::t_cmd  o_cmd
);
    import ppbt_pkg::*;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state       = r_state;
        o_cmd         = '0;
        o_cmd.div_sel = DIV_MEAN;
        o_in_ready    = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_state       = S_CHECK;
                end
            end
            S_CHECK: begin
                if (i_stat.below_finger) begin
                    o_cmd.no_finger = 1'b1;
                    n_state         = S_FINISH;
                end else begin
                    o_cmd.win_update = 1'b1;
                    n_state          = S_MEAN_GO;
                end
            end
            S_MEAN_GO: begin
                o_cmd.div_start = 1'b1;
                o_cmd.div_sel   = DIV_MEAN;
                n_state         = S_MEAN_WAIT;
            end
            S_MEAN_WAIT: begin
                if (i_stat.div_done) begin
                    n_state = S_PEAK;
                end
            end
            S_PEAK: begin
                o_cmd.peak_eval = 1'b1;
                if (i_stat.beat_go) begin
                    o_cmd.div_start = 1'b1;
                    o_cmd.div_sel   = DIV_RATE;
                    n_state         = S_RATE_WAIT;
                end else begin
                    n_state = S_FINISH;
                end
            end
            S_RATE_WAIT: begin
                if (i_stat.div_done) begin
                    o_cmd.rate_update = 1'b1;
                    n_state           = S_AVG_GO;
                end
            end
            S_AVG_GO: begin
                o_cmd.div_start = 1'b1;
                o_cmd.div_sel   = DIV_AVG;
                n_state         = S_AVG_WAIT;
            end
            S_AVG_WAIT: begin
                if (i_stat.div_done) begin
                    o_cmd.avg_eval = 1'b1;
                    n_state        = S_FINISH;
                end
            end
            S_FINISH: begin
                if (i_stat.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end
endmodule

FILE: hw/rtl/pulse_peak_bpm_tracker_unit.sv
// Pulse peak rate tracker top level: controller, datapath and register port.
//
// Each accepted item (an infrared sample with a millisecond timestamp) yields
// exactly one result item. A sample below the finger threshold skips the
// divider on its way to the result register. Any other sample passes
// through a shared two-bit-per-cycle divider once for the window mean; a
// sample that completes a valid beat interval uses the divider twice more,
// for 60000/interval and for the rate average. One item is worked on at a
// time; the next item is taken as soon as the previous result sits in the
// output register, which holds it until the sink takes it. Register writes
// are taken in any cycle and must only be issued while no item is in flight.
module pulse_peak_bpm_tracker_unit #(
    parameter int SAMPLE_DEPTH = ppbt_pkg::SAMPLE_DEPTH_DEF,
    parameter int RATE_DEPTH   = ppbt_pkg::RATE_DEPTH_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    ppbt_in_if.sink    i_in,
    ppbt_out_if.source o_out,
    ppbt_cfg_if.sink   i_cfg
);
    import ppbt_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    assign i_cfg.ready = 1'b1;

    ppbt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (i_in.ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    ppbt_datapath #(
        .SAMPLE_DEPTH (SAMPLE_DEPTH),
        .RATE_DEPTH   (RATE_DEPTH)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_ir_sample (i_in.ir_sample),
        .i_now_ms    (i_in.now_ms),
        .i_cfg_we    (i_cfg.valid),
        .i_cfg_index (i_cfg.index),
        .i_cfg_data  (i_cfg.data),
        .i_out_ready (o_out.ready),
        .o_out_valid (o_out.valid),
        .o_status    (o_out.status),
        .o_beat_seen (o_out.beat_seen),
        .o_beat_rate (o_out.beat_rate),
        .o_avg_rate  (o_out.avg_rate)
    );
endmodule

FILE: hw/rtl/ppbt_checker.sv
// Port-level checker for the pulse peak rate tracker, bound to the top level.
`include "pulse_peak_bpm_tracker_unit_defines.svh"

module ppbt_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_in_valid,
    input logic                          i_in_ready,
    input logic                          i_out_valid,
    input logic                          i_out_ready,
    input logic [ppbt_pkg::STATUS_W-1:0] i_status,
    input logic                          i_beat_seen,
    input logic [ppbt_pkg::RATE_W-1:0]   i_beat_rate,
    input logic [ppbt_pkg::AVG_W-1:0]    i_avg_rate
);
    import ppbt_pkg::*;

    // A waiting result must not change before it is taken.
    `PPBT_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid && $stable(i_status) && $stable(i_beat_rate) && $stable(i_avg_rate))

    // Only one item is in flight, so ready drops right after an acceptance.
    `PPBT_ASSERT_NXT(a_one_in_flight, i_clk, i_rst_n, i_in_valid && i_in_ready, !i_in_ready)

    `PPBT_ASSERT_IMP(a_no_finger_clear, i_clk, i_rst_n, i_out_valid && (i_status == ST_NO_FINGER), !i_beat_seen && (i_beat_rate == '0) && (i_avg_rate == '0))

    // Without a beat there is no rate and no verdict on the average.
    `PPBT_ASSERT_IMP(a_no_beat_quiet, i_clk, i_rst_n, i_out_valid && !i_beat_seen, (i_beat_rate == '0) && (i_avg_rate == '0) && ((i_status == ST_NO_FINGER) || (i_status == ST_NOTHING)))

    `PPBT_ASSERT_IMP(a_beat_has_rate, i_clk, i_rst_n, i_out_valid && i_beat_seen, (i_beat_rate != '0) && (i_status != ST_NO_FINGER))
endmodule

bind pulse_peak_bpm_tracker_unit ppbt_checker u_ppbt_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_status    (o_out.status),
    .i_beat_seen (o_out.beat_seen),
    .i_beat_rate (o_out.beat_rate),
    .i_avg_rate  (o_out.avg_rate)
);

FILE: verif/testbench.sv
// Self-checking testbench for the pulse peak rate tracker unit.
module testbench;
    import ppbt_pkg::*;

    localparam int IR_MAX      = (1 << IR_W) - 1;
    localparam int CYCLE_LIMIT = 400000;
    localparam int SETTLE_CYC  = 60;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic                beat_seen;
        logic [RATE_W-1:0]   beat_rate;
        logic [AVG_W-1:0]    avg_rate;
    } pulse_result_t;

    logic i_clk = 1'b0;
    logic i_rst_n;

    ppbt_in_if  in_ch();
    ppbt_out_if out_ch();
    ppbt_cfg_if cfg_ch();

    pulse_peak_bpm_tracker_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .i_cfg   (cfg_ch)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Register shadows.
    logic [IR_W-1:0]   finger_lvl, rise_lvl, fall_lvl;
    logic [TIME_W-1:0] ivl_min, ivl_max;
    logic [AVG_W-1:0]  ok_low, ok_high, clamp_lvl;

    // Tracker state as the predictor sees it.
    logic [IR_W-1:0]    ir_hist [SAMPLE_DEPTH_DEF];
    logic [2:0]         hist_pos;
    logic               peak_held;
    logic               first_peak_due;
    logic [TIME_W-1:0]  prev_peak_ms;
    logic [RATE_W-1:0]  bpm_hist [RATE_DEPTH_DEF];
    logic [1:0]         bpm_pos;
    logic [COUNT_W-1:0] beat_run;

    pulse_result_t pending_results[$];
    int unsigned   mismatch_count;
    int unsigned   items_sent;
    int unsigned   burst_left;
    int unsigned   cycle_count;
    logic [TIME_W-1:0] stamp_ms;

    task automatic reset_tracker_model;
        int i;
        finger_lvl = FINGER_THR_RST;
        rise_lvl   = RISE_THR_RST;
        fall_lvl   = FALL_THR_RST;
        ivl_min    = MIN_IVL_RST;
        ivl_max    = MAX_IVL_RST;
        ok_low     = ACCEPT_LOW_RST;
        ok_high    = ACCEPT_HI_RST;
        clamp_lvl  = CLAMP_LIM_RST;
        for (i = 0; i < SAMPLE_DEPTH_DEF; i++) ir_hist[i] = '0;
        for (i = 0; i < RATE_DEPTH_DEF; i++) bpm_hist[i] = '0;
        hist_pos       = '0;
        peak_held      = 1'b0;
        first_peak_due = 1'b1;
        prev_peak_ms   = '0;
        bpm_pos        = '0;
        beat_run       = '0;
    endtask

    // Advances the tracker state by one sample and returns the result it gives.
    function automatic pulse_result_t track_sample(input logic [IR_W-1:0] ir,
                                                   input logic [TIME_W-1:0] ms);
        pulse_result_t     r;
        logic [IR_W+2:0]   win_sum;
        logic [TIME_W-1:0] dt;
        int                dev;
        int                bpm_sum;
        int                avg;
        int                i;
        r = '0;
        r.status = ST_NOTHING;
        if (ir < finger_lvl) begin
            first_peak_due = 1'b1;
            beat_run       = '0;
            r.status       = ST_NO_FINGER;
            return r;
        end
        ir_hist[hist_pos] = ir;
        hist_pos = hist_pos + 3'd1;
        win_sum = '0;
        for (i = 0; i < SAMPLE_DEPTH_DEF; i++) win_sum = win_sum + ir_hist[i];
        dev = int'(ir) - int'(win_sum >> 3);
        if (dev > int'(rise_lvl) && !peak_held) begin
            peak_held = 1'b1;
            if (!first_peak_due) begin
                dt = ms - prev_peak_ms;
                if (dt > ivl_min && dt < ivl_max && dt != '0) begin
                    r.beat_rate = RATE_W'(32'(BPM_NUMERATOR) / 32'(dt));
                    r.beat_seen = 1'b1;
                    bpm_hist[bpm_pos] = r.beat_rate;
                    bpm_pos = bpm_pos + 2'd1;
                    bpm_sum = 0;
                    for (i = 0; i < RATE_DEPTH_DEF; i++) bpm_sum += int'(bpm_hist[i]);
                    avg = bpm_sum / RATE_DEPTH_DEF;
                    if (avg > int'(clamp_lvl)) avg = int'(CLAMP_VALUE);
                    if (beat_run != COUNT_MAX) beat_run = beat_run + 2'd1;
                    if (beat_run == COUNT_MAX) begin
                        r.avg_rate = AVG_W'(avg);
                        r.status = (avg > int'(ok_low) && avg < int'(ok_high)) ?
                                   ST_ACCEPTED : ST_REJECTED;
                    end
                end
            end
            prev_peak_ms   = ms;
            first_peak_due = 1'b0;
        end
        if (dev < int'(fall_lvl)) peak_held = 1'b0;
        return r;
    endfunction

    // Sends one item; the sender sends bursts of random length, most of them preceded by a gap.
    task automatic send_sample(input logic [IR_W-1:0] ir, input logic [TIME_W-1:0] ms);
        int unsigned gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(12, 1);
            gap = ($urandom_range(2, 0) == 0) ? 0 : $urandom_range(50, 1);
            if (gap != 0) begin
                in_ch.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        in_ch.valid     <= 1'b1;
        in_ch.ir_sample <= ir;
        in_ch.now_ms    <= ms;
        do @(posedge i_clk); while (!in_ch.ready);
        pending_results.push_back(track_sample(ir, ms));
        items_sent++;
    endtask

    // One pulse: a crest at the running stamp, then fill samples at the base level.
    task automatic send_pulse(input int unsigned base_lvl, input int unsigned crest_lvl,
                              input int unsigned span_ms, input int unsigned fill);
        int unsigned k;
        int unsigned step;
        step = span_ms / (fill + 1);
        send_sample(IR_W'(crest_lvl), stamp_ms);
        for (k = 1; k <= fill; k++)
            send_sample(IR_W'(base_lvl), TIME_W'(stamp_ms + k * step));
        stamp_ms = TIME_W'(stamp_ms + span_ms);
    endtask

    task automatic wait_idle;
        in_ch.valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYC) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        do @(posedge i_clk); while (!cfg_ch.ready);
        case (idx)
            CFG_FINGER_THR: finger_lvl = val;
            CFG_RISE_THR:   rise_lvl   = val;
            CFG_FALL_THR:   fall_lvl   = val;
            CFG_MIN_IVL:    ivl_min    = val[TIME_W-1:0];
            CFG_MAX_IVL:    ivl_max    = val[TIME_W-1:0];
            CFG_ACCEPT_LOW: ok_low     = val[AVG_W-1:0];
            CFG_ACCEPT_HI:  ok_high    = val[AVG_W-1:0];
            CFG_CLAMP_LIM:  clamp_lvl  = val[AVG_W-1:0];
            default: ;
        endcase
    endtask

    task automatic program_registers(input logic [IR_W-1:0] fng, input logic [IR_W-1:0] rise,
                                     input logic [IR_W-1:0] fall,
                                     input logic [TIME_W-1:0] lo_ms,
                                     input logic [TIME_W-1:0] hi_ms,
                                     input logic [AVG_W-1:0] acc_lo,
                                     input logic [AVG_W-1:0] acc_hi,
                                     input logic [AVG_W-1:0] clamp);
        write_reg(CFG_FINGER_THR, fng);
        write_reg(CFG_RISE_THR, rise);
        write_reg(CFG_FALL_THR, fall);
        write_reg(CFG_MIN_IVL, CFG_DATA_W'(lo_ms));
        write_reg(CFG_MAX_IVL, CFG_DATA_W'(hi_ms));
        write_reg(CFG_ACCEPT_LOW, CFG_DATA_W'(acc_lo));
        write_reg(CFG_ACCEPT_HI, CFG_DATA_W'(acc_hi));
        write_reg(CFG_CLAMP_LIM, CFG_DATA_W'(clamp));
        cfg_ch.valid <= 1'b0;
    endtask

    // A pulse train shaped by the current settings, with occasional dropouts and noise.
    task automatic random_train(input int unsigned beats);
        int unsigned n, base_lvl, crest_lvl, span, fill_cnt;
        base_lvl = int'(finger_lvl) + $urandom_range(20000, 0);
        if (base_lvl > IR_MAX) base_lvl = IR_MAX;
        crest_lvl = base_lvl + int'(rise_lvl) + $urandom_range(60000, 1);
        if (crest_lvl > IR_MAX) crest_lvl = IR_MAX;
        fill_cnt = $urandom_range(6, 1);
        for (n = 0; n < beats; n++) begin
            case ($urandom_range(19, 0))
                0: if (finger_lvl != '0)
                    send_sample(IR_W'($urandom_range(int'(finger_lvl) - 1, 0)), stamp_ms);
                1: send_sample(IR_W'($urandom), TIME_W'($urandom));
                default: ;
            endcase
            if (int'(ivl_max) > int'(ivl_min) + 1 && $urandom_range(4, 0) != 0)
                span = $urandom_range(int'(ivl_max) - 1, int'(ivl_min) + 1);
            else
                span = $urandom_range(int'(ivl_max) + 300, 0);
            send_pulse(base_lvl, crest_lvl, span, fill_cnt);
        end
    endtask

    task automatic test_directed;
        int k;
        stamp_ms = 16'd64800;
        send_sample('0, 16'd64600);
        send_sample(FINGER_THR_RST - 1'b1, 16'd64700);
        // Crests every 800 ms across the timestamp wrap; the beat count saturates.
        for (k = 0; k < 6; k++) send_pulse(FINGER_THR_RST, IR_MAX, 800, 2);
        // Intervals exactly at the lower and upper limits give no beat.
        send_pulse(FINGER_THR_RST, IR_MAX, MIN_IVL_RST, 2);
        send_pulse(FINGER_THR_RST, IR_MAX, MAX_IVL_RST, 2);
        send_pulse(FINGER_THR_RST, IR_MAX, 900, 2);
    endtask

    task automatic test_register_extremes;
        int k;
        wait_idle();
        program_registers(IR_MAX, IR_MAX, IR_MAX, '1, '1, '1, '1, '1);
        for (k = 0; k < 10; k++)
            send_sample((k % 2 == 0) ? IR_W'(IR_MAX) : IR_W'($urandom), TIME_W'($urandom));

        // Widest interval window and tiny intervals: the rate sum far exceeds 16 bits.
        wait_idle();
        program_registers('0, '0, '0, '0, '1, '0, '1, '0);
        for (k = 0; k < 8; k++) send_pulse(0, 1 + k * 40, (k % 2) + 1, 1);

        // With fall above rise, a mark is set and cleared by the same sample.
        wait_idle();
        program_registers('0, '0, IR_MAX, '0, '1, '0, '1, '1);
        for (k = 0; k < 10; k++) begin
            send_sample(IR_W'(1000 + 5000 * k), stamp_ms);
            stamp_ms = TIME_W'(stamp_ms + k + 1);
        end

        // No interval fits between a zero minimum and a maximum of one.
        wait_idle();
        program_registers(FINGER_THR_RST, RISE_THR_RST, FALL_THR_RST, '0, 16'd1,
                          ACCEPT_LOW_RST, ACCEPT_HI_RST, CLAMP_LIM_RST);
        random_train(4);
    endtask

    task automatic test_random_sweep;
        int unsigned goal, phase_goal;
        int unsigned rise;
        int unsigned lo_ms;
        goal = items_sent + 650;
        while (items_sent < goal) begin
            wait_idle();
            if ($urandom_range(4, 0) == 0) begin
                program_registers(FINGER_THR_RST, RISE_THR_RST, FALL_THR_RST, MIN_IVL_RST,
                                  MAX_IVL_RST, ACCEPT_LOW_RST, ACCEPT_HI_RST, CLAMP_LIM_RST);
            end else begin
                rise  = $urandom_range(3000, 1);
                lo_ms = $urandom_range(500, 0);
                program_registers(IR_W'($urandom_range(20000, 0)), IR_W'(rise),
                                  IR_W'($urandom_range(rise + rise / 2, 0)),
                                  TIME_W'(lo_ms), TIME_W'($urandom_range(3000, lo_ms + 1)),
                                  AVG_W'($urandom_range(90, 30)),
                                  AVG_W'($urandom_range(200, 70)),
                                  AVG_W'($urandom_range(255, 50)));
            end
            phase_goal = items_sent + 130;
            while (items_sent < phase_goal && items_sent < goal)
                random_train($urandom_range(10, 2));
        end
    endtask

    // Result checker.
    always @(posedge i_clk) begin
        pulse_result_t got, want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            got = '{out_ch.status, out_ch.beat_seen, out_ch.beat_rate, out_ch.avg_rate};
            if (pending_results.size() == 0) begin
                if (mismatch_count < 10)
                    $display("unexpected result: status %0d beat %0d rate %0d avg %0d",
                             got.status, got.beat_seen, got.beat_rate, got.avg_rate);
                mismatch_count++;
            end else begin
                want = pending_results.pop_front();
                if (got != want) begin
                    if (mismatch_count < 10)
                        $display({"mismatch: status %0d/%0d beat %0d/%0d rate %0d/%0d ",
                                  "avg %0d/%0d (expected/actual)"},
                                 want.status, got.status, want.beat_seen, got.beat_seen,
                                 want.beat_rate, got.beat_rate, want.avg_rate, got.avg_rate);
                    mismatch_count++;
                end
            end
        end
    end

    // The receiver stalls on a rotating pattern that is redrawn now and then.
    initial begin : sink_stall
        logic [15:0] pattern;
        int unsigned left;
        pattern = '1;
        left = 0;
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (left == 0) begin
                left = $urandom_range(300, 40);
                case ($urandom_range(3, 0))
                    0: pattern = '1;
                    1: pattern = 16'h8000;
                    2: pattern = 16'($urandom) | 16'h0101;
                    default: pattern = 16'($urandom) | 16'h0001;
                endcase
            end
            left--;
            out_ch.ready <= pattern[0];
            pattern = {pattern[0], pattern[15:1]};
        end
    end

    // The limit covers every item with the longest gap, stall and block latency.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    initial begin
        i_rst_n         <= 1'b0;
        in_ch.valid     <= 1'b0;
        in_ch.ir_sample <= '0;
        in_ch.now_ms    <= '0;
        cfg_ch.valid    <= 1'b0;
        cfg_ch.index    <= '0;
        cfg_ch.data     <= '0;
        mismatch_count = 0;
        items_sent     = 0;
        burst_left     = 0;
        cycle_count    = 0;
        stamp_ms       = '0;
        reset_tracker_model();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_register_extremes();
        test_random_sweep();
        wait_idle();

        if (mismatch_count == 0 && pending_results.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
